FILE: rtl/core/vab_pkg.sv
`timescale 1ns / 1ps
package vab_pkg;

    localparam int MAX_LEN_DEF  = 16;
    localparam int CORDIC_STEPS = 21;
    localparam int STEP_W       = 5;
    localparam int DOT_W        = 48;
    localparam int SQ_W         = 48;
    localparam logic [22:0] PI_Q20      = 23'd3294199;
    localparam logic [22:0] HALF_PI_Q20 = 23'd1647099;
    localparam logic [15:0] DEG_180_Q8  = 16'd46080;
    // floor(2^38 / PI_Q20); the degree estimate it gives is low by at most one
    localparam logic [16:0] DEG_RECIP   = 17'd83443;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_LEN = 2'd1,
        ST_TOO_LONG = 2'd2
    } status_t;

    // closed vector sums handed from the front end to the back end
    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [SQ_W-1:0]         sq_a;
        logic [SQ_W-1:0]         sq_b;
        status_t                 status;
    } job_t;

    typedef enum logic [3:0] {
        BE_IDLE,
        BE_NORM,
        BE_SQRT,
        BE_MUL,
        BE_DIV,
        BE_CLAMP,
        BE_SQR,
        BE_SIN,
        BE_LOAD,
        BE_CORDIC,
        BE_THETA,
        BE_DEG,
        BE_DEGDIV,
        BE_OUT
    } be_state_t;

    function automatic logic [20:0] atan_q20(input logic [STEP_W-1:0] i);
        case (i)
            5'd0:  atan_q20 = 21'd823550;
            5'd1:  atan_q20 = 21'd486170;
            5'd2:  atan_q20 = 21'd256879;
            5'd3:  atan_q20 = 21'd130396;
            5'd4:  atan_q20 = 21'd65451;
            5'd5:  atan_q20 = 21'd32757;
            5'd6:  atan_q20 = 21'd16383;
            5'd7:  atan_q20 = 21'd8192;
            5'd8:  atan_q20 = 21'd4096;
            5'd9:  atan_q20 = 21'd2048;
            5'd10: atan_q20 = 21'd1024;
            5'd11: atan_q20 = 21'd512;
            5'd12: atan_q20 = 21'd256;
            5'd13: atan_q20 = 21'd128;
            5'd14: atan_q20 = 21'd64;
            5'd15: atan_q20 = 21'd32;
            5'd16: atan_q20 = 21'd16;
            5'd17: atan_q20 = 21'd8;
            5'd18: atan_q20 = 21'd4;
            5'd19: atan_q20 = 21'd2;
            5'd20: atan_q20 = 21'd1;
            default: atan_q20 = 21'd0;
        endcase
    endfunction

endpackage

FILE: rtl/core/vector_angle_between.sv
`timescale 1ns / 1ps
// Angle between two signed 16-bit vectors streamed as element pairs, s_last
// closing both. Pairs are taken one per cycle into the accumulators while
// s_ready is high; the closed sums move through a one-job queue to a
// sequential back end that normalizes, takes both square roots, divides,
// takes the sine root, loads and runs a 21-step CORDIC and a reciprocal
// degree conversion; status 1 and 2 results skip these steps. The next
// vector streams in meanwhile; its last pair waits while the queue is full.
// Status 2 flags more than MAX_LEN pairs, status 1 a zero-length vector,
// with both angles zero.
module vector_angle_between #(
    parameter int MAX_LEN = vab_pkg::MAX_LEN_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_a_elem,
    input  logic signed [15:0] s_b_elem,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_radians,
    output logic [15:0]        m_degrees,
    output logic [1:0]         m_status
);
    logic          job_valid, job_ready;
    vab_pkg::job_t job;

    vab_front #(.MAX_LEN(MAX_LEN)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_a_elem, .s_b_elem, .s_last,
        .job_valid, .job_ready, .job
    );

    vab_back u_back (
        .aclk, .aresetn, .job_valid, .job_ready, .job,
        .m_valid, .m_ready, .m_radians, .m_degrees, .m_status
    );
endmodule

FILE: rtl/core/vab_front.sv
`timescale 1ns / 1ps
module vab_front #(
    parameter int MAX_LEN = vab_pkg::MAX_LEN_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_a_elem,
    input  logic signed [15:0] s_b_elem,
    input  logic               s_last,
    output logic               job_valid,
    input  logic               job_ready,
    output vab_pkg::job_t      job
);
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    logic signed [vab_pkg::DOT_W-1:0] dot_reg;
    logic [vab_pkg::SQ_W-1:0]         sqa_reg, sqb_reg;
    logic [CNT_W-1:0]                 cnt_reg;
    logic                             ovf_reg;
    logic                             take, room;
    logic signed [vab_pkg::DOT_W-1:0] dot_next;
    logic [vab_pkg::SQ_W-1:0]         sqa_next, sqb_next;
    logic signed [31:0]               pab, paa, pbb;

    // the queue holds one closed job; a last pair waits until it is free
    assign s_ready = !s_last || !job_valid || job_ready;
    assign take    = s_valid && s_ready;
    assign room    = cnt_reg < CNT_W'(MAX_LEN);

    assign pab = s_a_elem * s_b_elem;
    assign paa = s_a_elem * s_a_elem;
    assign pbb = s_b_elem * s_b_elem;
    assign dot_next = room ? dot_reg + vab_pkg::DOT_W'(pab) : dot_reg;
    assign sqa_next = room ? sqa_reg + vab_pkg::SQ_W'($unsigned(paa)) : sqa_reg;
    assign sqb_next = room ? sqb_reg + vab_pkg::SQ_W'($unsigned(pbb)) : sqb_reg;

    // accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg <= '0; sqa_reg <= '0; sqb_reg <= '0;
            cnt_reg <= '0; ovf_reg <= 1'b0;
        end else if (take) begin
            if (s_last) begin
                dot_reg <= '0; sqa_reg <= '0; sqb_reg <= '0;
                cnt_reg <= '0; ovf_reg <= 1'b0;
            end else begin
                dot_reg <= dot_next; sqa_reg <= sqa_next; sqb_reg <= sqb_next;
                if (room) cnt_reg <= cnt_reg + 1'b1;
                else      ovf_reg <= 1'b1;
            end
        end
    end

    // job queue stage with classification
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid <= 1'b0;
        end else begin
            if (take && s_last) begin
                job_valid <= 1'b1;
                job.dot  <= dot_next;
                job.sq_a <= sqa_next;
                job.sq_b <= sqb_next;
                if (ovf_reg || !room)
                    job.status <= vab_pkg::ST_TOO_LONG;
                else if (sqa_next == '0 || sqb_next == '0)
                    job.status <= vab_pkg::ST_ZERO_LEN;
                else
                    job.status <= vab_pkg::ST_OK;
            end else if (job_valid && job_ready) begin
                job_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_LEN)) else $error("count past limit");
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        take && s_last |=> cnt_reg == '0 && !ovf_reg) else $error("state not cleared");
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> !room) else $error("overflow before full");
`endif
endmodule

FILE: rtl/core/vab_back.sv
`timescale 1ns / 1ps
module vab_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          job_valid,
    output logic          job_ready,
    input  vab_pkg::job_t job,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [15:0]   m_radians,
    output logic [15:0]   m_degrees,
    output logic [1:0]    m_status
);
    vab_pkg::be_state_t state_reg, state_next;
    logic [6:0]   cnt_reg;
    logic         neg_reg;
    logic [63:0]  mag_reg;
    logic [63:0]  sa_reg, sb_reg;   // normalized square sums, then radicands
    logic [5:0]   ka_reg, kb_reg;
    logic [63:0]  ra_reg, rb_reg;   // isqrt remainders
    logic [31:0]  ma_reg, mb_reg;   // roots
    logic [63:0]  m_reg;            // divisor
    logic [95:0]  num_reg;          // shifted dividend
    logic [64:0]  rem_reg;
    logic [30:0]  q_reg;
    logic signed [33:0] x_reg, y_reg;
    logic signed [23:0] z_reg;
    logic [22:0]  th_reg;
    logic [38:0]  dn_reg;
    logic [15:0]  dq_reg;
    logic [15:0]  rad_reg, deg_reg;
    logic [1:0]   st_reg;
    logic [63:0]  mag;
    logic [64:0]  rtrial;
    logic signed [33:0] xs, ys;
    logic [63:0]  tra, trb;
    logic [48:0]  dprod;
    logic [38:0]  dbound;

    assign job_ready = (state_reg == vab_pkg::BE_IDLE);
    assign mag = job.dot[vab_pkg::DOT_W-1] ? 64'(-job.dot) : 64'(job.dot);
    assign rtrial = {rem_reg[63:0], num_reg[95]} ;
    assign xs = x_reg >>> cnt_reg[4:0];
    assign ys = y_reg >>> cnt_reg[4:0];
    // one root bit per cycle: trial of (4r+1) against the remainder and top radicand pair
    assign tra = {ra_reg[61:0], sa_reg[63:62]} ;
    assign trb = {rb_reg[61:0], sb_reg[63:62]} ;
    // degree quotient estimate by reciprocal, then one correction step
    assign dprod  = 49'(dn_reg[37:6]) * 49'(vab_pkg::DEG_RECIP);
    assign dbound = (39'(dq_reg) + 39'd1) * 39'(vab_pkg::PI_Q20);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            vab_pkg::BE_IDLE:   if (job_valid) begin
                state_next = (job.status == vab_pkg::ST_OK) ? vab_pkg::BE_NORM : vab_pkg::BE_OUT;
            end
            vab_pkg::BE_NORM:   if (sa_reg[63:60] != 4'd0 && sb_reg[63:60] != 4'd0)
                                    state_next = vab_pkg::BE_SQRT;
            vab_pkg::BE_SQRT:   if (cnt_reg == 7'd31) state_next = vab_pkg::BE_MUL;
            vab_pkg::BE_MUL:    state_next = vab_pkg::BE_DIV;
            vab_pkg::BE_DIV:    if (cnt_reg == 7'd95) state_next = vab_pkg::BE_CLAMP;
            vab_pkg::BE_CLAMP:  state_next = vab_pkg::BE_SQR;
            vab_pkg::BE_SQR:    state_next = vab_pkg::BE_SIN;
            vab_pkg::BE_SIN:    if (cnt_reg == 7'd31) state_next = vab_pkg::BE_LOAD;
            vab_pkg::BE_LOAD:   state_next = vab_pkg::BE_CORDIC;
            vab_pkg::BE_CORDIC: if (cnt_reg == 7'(vab_pkg::CORDIC_STEPS - 1))
                                    state_next = vab_pkg::BE_THETA;
            vab_pkg::BE_THETA:  state_next = vab_pkg::BE_DEG;
            vab_pkg::BE_DEG:    state_next = vab_pkg::BE_DEGDIV;
            vab_pkg::BE_DEGDIV: if (cnt_reg == 7'd1) state_next = vab_pkg::BE_OUT;
            vab_pkg::BE_OUT:    if (!m_valid || m_ready) state_next = vab_pkg::BE_IDLE;
            default:            state_next = vab_pkg::BE_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= vab_pkg::BE_IDLE;
        else          state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (m_valid && m_ready && state_reg != vab_pkg::BE_OUT) m_valid <= 1'b0;
            case (state_reg)
                vab_pkg::BE_IDLE: begin
                    cnt_reg <= '0;
                    neg_reg <= job.dot[vab_pkg::DOT_W-1];
                    mag_reg <= mag;
                    sa_reg  <= 64'(job.sq_a);
                    sb_reg  <= 64'(job.sq_b);
                    ka_reg  <= '0; kb_reg <= '0;
                    st_reg  <= job.status;
                    rad_reg <= '0; deg_reg <= '0;
                end
                vab_pkg::BE_NORM: begin
                    if (sa_reg[63:60] == 4'd0) begin
                        sa_reg <= sa_reg << 2; ka_reg <= ka_reg + 6'd2;
                    end
                    if (sb_reg[63:60] == 4'd0) begin
                        sb_reg <= sb_reg << 2; kb_reg <= kb_reg + 6'd2;
                    end
                    ra_reg <= '0; rb_reg <= '0; ma_reg <= '0; mb_reg <= '0;
                end
                vab_pkg::BE_SQRT, vab_pkg::BE_SIN: begin
                    cnt_reg <= (cnt_reg == 7'd31) ? 7'd0 : cnt_reg + 7'd1;
                    sa_reg  <= sa_reg << 2;
                    sb_reg  <= sb_reg << 2;
                    if (tra >= {ma_reg, 2'b01}) begin
                        ra_reg <= tra - 64'({ma_reg, 2'b01});
                        ma_reg <= {ma_reg[30:0], 1'b1};
                    end else begin
                        ra_reg <= tra;
                        ma_reg <= {ma_reg[30:0], 1'b0};
                    end
                    if (trb >= {mb_reg, 2'b01}) begin
                        rb_reg <= trb - 64'({mb_reg, 2'b01});
                        mb_reg <= {mb_reg[30:0], 1'b1};
                    end else begin
                        rb_reg <= trb;
                        mb_reg <= {mb_reg[30:0], 1'b0};
                    end
                end
                vab_pkg::BE_MUL: begin
                    m_reg   <= ma_reg * mb_reg;
                    num_reg <= 96'(mag_reg) << (7'(ka_reg + kb_reg) >> 1) << 30;
                    rem_reg <= '0;
                    q_reg   <= '0;
                end
                vab_pkg::BE_DIV: begin
                    // restoring division, one quotient bit per cycle
                    cnt_reg <= (cnt_reg == 7'd95) ? 7'd0 : cnt_reg + 7'd1;
                    num_reg <= num_reg << 1;
                    if (rtrial >= {1'b0, m_reg}) begin
                        rem_reg <= rtrial - {1'b0, m_reg};
                        q_reg   <= (q_reg[30] || q_reg[29:0] == 30'h3fffffff) ?
                                   {1'b1, 30'd0} + 31'd1 : {q_reg[29:0], 1'b1};
                    end else begin
                        rem_reg <= rtrial;
                        q_reg   <= q_reg[30] ? q_reg : {q_reg[29:0], 1'b0};
                    end
                end
                vab_pkg::BE_CLAMP: begin
                    if (q_reg > {1'b1, 30'd0}) q_reg <= {1'b1, 30'd0};
                end
                vab_pkg::BE_SQR: begin
                    sb_reg <= (64'd1 << 60) - 64'(q_reg) * 64'(q_reg);
                    sa_reg <= '0;
                    ra_reg <= '0; rb_reg <= '0; ma_reg <= '0; mb_reg <= '0;
                    x_reg  <= 34'(q_reg);
                    z_reg  <= '0;
                end
                vab_pkg::BE_LOAD: begin
                    // sine root becomes the cordic y input
                    y_reg   <= 34'(mb_reg);
                    cnt_reg <= '0;
                end
                vab_pkg::BE_CORDIC: begin
                    cnt_reg <= (cnt_reg == 7'(vab_pkg::CORDIC_STEPS - 1)) ? 7'd0 : cnt_reg + 7'd1;
                    if (y_reg > 0) begin
                        x_reg <= x_reg + ys; y_reg <= y_reg - xs;
                        z_reg <= z_reg + 24'(vab_pkg::atan_q20(cnt_reg[4:0]));
                    end else begin
                        x_reg <= x_reg - ys; y_reg <= y_reg + xs;
                        z_reg <= z_reg - 24'(vab_pkg::atan_q20(cnt_reg[4:0]));
                    end
                end
                vab_pkg::BE_THETA: begin
                    if (z_reg < 0)
                        th_reg <= neg_reg ? vab_pkg::PI_Q20 : 23'd0;
                    else if (z_reg > 24'(vab_pkg::HALF_PI_Q20))
                        th_reg <= neg_reg ? vab_pkg::PI_Q20 - vab_pkg::HALF_PI_Q20
                                          : vab_pkg::HALF_PI_Q20;
                    else
                        th_reg <= neg_reg ? vab_pkg::PI_Q20 - z_reg[22:0] : z_reg[22:0];
                end
                vab_pkg::BE_DEG: begin
                    rad_reg <= 16'((24'(th_reg) + 24'd32) >> 6);
                    dn_reg  <= 39'(th_reg) * 39'(vab_pkg::DEG_180_Q8)
                               + 39'(vab_pkg::PI_Q20 >> 1);
                    dq_reg  <= '0;
                    cnt_reg <= '0;
                end
                vab_pkg::BE_DEGDIV: begin
                    // estimate first, then add one where the remainder allows
                    cnt_reg <= (cnt_reg == 7'd1) ? 7'd0 : cnt_reg + 7'd1;
                    if (cnt_reg == 7'd0)
                        dq_reg <= dprod[47:32];
                    else
                        deg_reg <= (dn_reg >= dbound) ? dq_reg + 16'd1 : dq_reg;
                end
                vab_pkg::BE_OUT: begin
                    if (!m_valid || m_ready) begin
                        m_valid   <= 1'b1;
                        m_radians <= rad_reg;
                        m_degrees <= deg_reg;
                        m_status  <= st_reg;
                    end
                end
                default: cnt_reg <= '0;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_idle_take: assert property (@(posedge aclk) disable iff (!aresetn)
        job_ready |-> state_reg == vab_pkg::BE_IDLE) else $error("ready outside idle");
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != vab_pkg::ST_OK |-> m_radians == '0 && m_degrees == '0)
        else $error("nonzero angle on error");
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_radians <= 16'd51472 && m_degrees <= 16'd46080)
        else $error("angle out of range");
`endif
endmodule

FILE: tb/sv/tb_vector_angle_between.sv
`timescale 1ns / 1ps
module tb_vector_angle_between;

    // expected angle result of one closed vector pair
    typedef struct {
        logic [15:0]      radians;
        logic [15:0]      degrees;
        vab_pkg::status_t status;
    } angle_result_t;

    localparam int MAX_PAIRS   = vab_pkg::MAX_LEN_DEF;
    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 400;
    localparam longint PI_Q20_L      = 3294199;
    localparam longint HALF_PI_Q20_L = 1647099;
    localparam longint DEG_180_L     = 46080;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_a_elem;
    logic signed [15:0] s_b_elem;
    logic               s_last;
    logic               m_valid;
    logic               m_ready;
    logic [15:0]        m_radians;
    logic [15:0]        m_degrees;
    logic [1:0]         m_status;

    // running sums of the vectors being streamed in
    longint      run_dot;
    bit [63:0]   run_sq_a;
    bit [63:0]   run_sq_b;
    int          run_count;
    bit          run_overflow;

    angle_result_t pending_angles[$];
    int  mismatch_count;
    bit  failed;
    int  idle_cycles;
    bit  src_no_gaps;
    bit  sink_no_stalls;
    int  pairs_sent;

    longint cordic_atan[21] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
                                8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16,
                                8, 4, 2, 1};

    vector_angle_between DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_a_elem  (s_a_elem),
        .s_b_elem  (s_b_elem),
        .s_last    (s_last),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_radians (m_radians),
        .m_degrees (m_degrees),
        .m_status  (m_status)
    );

    // clock
    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // bitwise integer square root, floor
    function automatic bit [63:0] int_sqrt(input bit [63:0] v);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // scale a square sum into [2^60, 2^62) by an even shift and take its root
    function automatic bit [63:0] scaled_root(input bit [63:0] s, output int shift);
        shift = 0;
        while (s < (64'd1 << 60) && shift < 60) begin
            s = s << 2;
            shift += 2;
        end
        return int_sqrt(s);
    endfunction

    // angle in Q.20 radians from the closed sums
    function automatic longint angle_of_sums(input longint dot, input bit [63:0] sa,
                                             input bit [63:0] sb);
        int        ka;
        int        kb;
        bit [63:0] ra;
        bit [63:0] rb;
        bit [63:0] prod;
        bit [63:0] mag;
        bit [63:0] rem;
        bit [63:0] quo;
        bit [63:0] sine;
        bit        neg;
        longint    x;
        longint    y;
        longint    z;
        longint    xs;
        longint    ys;
        ra   = scaled_root(sa, ka);
        rb   = scaled_root(sb, kb);
        prod = ra * rb;
        neg  = dot < 0;
        mag  = neg ? 64'd0 - 64'(dot) : 64'(dot);
        rem  = mag << ((ka + kb) / 2);
        quo  = rem / prod;
        rem  = rem % prod;
        for (int i = 0; i < 30; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= prod) begin
                rem = rem - prod;
                quo = quo | 64'd1;
            end
        end
        // cosine beyond one is clamped
        if (quo > (64'd1 << 30)) quo = 64'd1 << 30;
        sine = int_sqrt((64'd1 << 60) - quo * quo);
        x = longint'(quo);
        y = longint'(sine);
        z = 0;
        for (int i = 0; i < 21; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys;
                y -= xs;
                z += cordic_atan[i];
            end else begin
                x -= ys;
                y += xs;
                z -= cordic_atan[i];
            end
        end
        if (z < 0) z = 0;
        if (z > HALF_PI_Q20_L) z = HALF_PI_Q20_L;
        return neg ? PI_Q20_L - z : z;
    endfunction

    // fold one accepted pair into the sums; queue a result on the closing pair
    task automatic predict_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                                input bit last);
        angle_result_t res;
        longint        th;
        longint        la;
        longint        lb;
        la = a;
        lb = b;
        if (run_count < MAX_PAIRS) begin
            run_dot  += la * lb;
            run_sq_a += 64'(la * la);
            run_sq_b += 64'(lb * lb);
            run_count++;
        end else begin
            run_overflow = 1'b1;
        end
        if (last) begin
            res.radians = 0;
            res.degrees = 0;
            if (run_overflow) begin
                res.status = vab_pkg::ST_TOO_LONG;
            end else if (run_sq_a == 0 || run_sq_b == 0) begin
                res.status = vab_pkg::ST_ZERO_LEN;
            end else begin
                res.status  = vab_pkg::ST_OK;
                th          = angle_of_sums(run_dot, run_sq_a, run_sq_b);
                res.radians = 16'((th + 32) >>> 6);
                res.degrees = 16'((th * DEG_180_L + PI_Q20_L / 2) / PI_Q20_L);
            end
            pending_angles.push_back(res);
            run_dot      = 0;
            run_sq_a     = 0;
            run_sq_b     = 0;
            run_count    = 0;
            run_overflow = 1'b0;
        end
    endtask

    // send one element pair and wait for its transaction
    task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                             input bit last);
        int gap;
        gap = src_no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  = 1'b1;
        s_a_elem = a;
        s_b_elem = b;
        s_last   = last;
        do @(posedge aclk); while (!s_ready);
        predict_pair(a, b, last);
        pairs_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // one vector pair of given length, element style picked by mode
    task automatic send_vector(input int len, input int mode);
        logic signed [15:0] a;
        logic signed [15:0] b;
        int                 k;
        k = int'($urandom_range(0, 6)) - 3;
        for (int i = 0; i < len; i++) begin
            a = 16'($urandom);
            b = 16'($urandom);
            case (mode)
                1: a = 16'($urandom_range(0, 15)) - 16'sd8;
                2: b = a;
                3: b = -a;
                4: b = 16'((a >>> 2) * k);
                5: a = 0;
                6: b = 0;
                default: ;
            endcase
            send_pair(a, b, i == len - 1);
        end
    endtask

    task automatic wait_drained();
        while (pending_angles.size() != 0) @(negedge aclk);
    endtask

    task automatic test_directed_cases();
        send_pair(16'sd32767, 16'sd32767, 1'b1);
        send_pair(-16'sd32768, 16'sd32767, 1'b1);
        send_pair(-16'sd32768, -16'sd32768, 1'b1);
        send_pair(16'sd1, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd1, 1'b1);
        send_pair(16'sd0, 16'sd5, 1'b1);
        send_pair(16'sd7, 16'sd0, 1'b1);
        send_pair(16'sd0, 16'sd0, 1'b1);
        send_pair(16'sd3, 16'sd6, 1'b0);
        send_pair(16'sd4, 16'sd8, 1'b1);
    endtask

    // pairs beyond the maximum length, plus an overflow on a zero vector
    task automatic test_overflow();
        for (int i = 0; i <= MAX_PAIRS; i++)
            send_pair(16'($urandom), 16'($urandom), i == MAX_PAIRS);
        for (int i = 0; i <= MAX_PAIRS + 2; i++)
            send_pair(16'sd0, 16'($urandom), i == MAX_PAIRS + 2);
    endtask

    // sender holds off until every queued result is out
    task automatic test_drain_pause();
        send_vector(4, 0);
        wait_drained();
        send_vector(1, 0);
        send_vector(16, 2);
    endtask

    task automatic test_random_vectors();
        int len;
        int mode;
        while (pairs_sent < 1200) begin
            src_no_gaps    = ($urandom_range(0, 7) == 0);
            sink_no_stalls = ($urandom_range(0, 7) == 0);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20)
                                                 : $urandom_range(1, MAX_PAIRS);
            mode = $urandom_range(0, 6);
            send_vector(len, mode);
        end
        src_no_gaps    = 1'b0;
        sink_no_stalls = 1'b0;
    endtask

    // result sink with random stalls
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            gap = sink_no_stalls ? 0 : $urandom_range(0, 9);
            m_ready = 1'b0;
            repeat (gap) @(negedge aclk);
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        angle_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_angles.size() == 0) begin
                failed = 1'b1;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: rad=%0d deg=%0d status=%0d",
                             m_radians, m_degrees, m_status);
            end else begin
                exp_res = pending_angles.pop_front();
                if (m_radians !== exp_res.radians || m_degrees !== exp_res.degrees
                    || m_status !== exp_res.status) begin
                    failed = 1'b1;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp rad=%0d deg=%0d status=%0d, got rad=%0d deg=%0d status=%0d",
                                 exp_res.radians, exp_res.degrees, exp_res.status,
                                 m_radians, m_degrees, m_status);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_a_elem       = '0;
        s_b_elem       = '0;
        s_last         = 1'b0;
        run_dot        = 0;
        run_sq_a       = 0;
        run_sq_b       = 0;
        run_count      = 0;
        run_overflow   = 1'b0;
        mismatch_count = 0;
        failed         = 1'b0;
        idle_cycles    = 0;
        src_no_gaps    = 1'b0;
        sink_no_stalls = 1'b0;
        pairs_sent     = 0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed_cases();
        test_overflow();
        test_drain_pause();
        test_random_vectors();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (!failed && pending_angles.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: vector_angle_between.f
rtl/core/vab_pkg.sv
rtl/core/vab_front.sv
rtl/core/vab_back.sv
rtl/core/vector_angle_between.sv
tb/sv/tb_vector_angle_between.sv
